>>> rtl/gncd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncd_pkg
// Shared types and constants for the grid node great-circle distance pipeline:
// angle format, CORDIC arctangent table, per-axis grid constants, scaling.
// ----------------------------------------------------------------------------
package gncd_pkg;

  // Degrees carry this many fraction bits
  localparam int AngleFracBits = 16;
  // 360 degrees in that format
  localparam logic [24:0] FullTurnQ = 25'(360 * (2 ** AngleFracBits));

  // Node id and row widths
  localparam int IdW  = 32;
  localparam int RowW = 16;

  // Centre lanes: west-east for both nodes, then south-north for both nodes
  localparam int NumLanes = 4;

  // CORDIC
  localparam int CordicSteps = 32;
  // Inverse CORDIC gain, 30 fraction bits
  localparam logic [31:0] GainQ30 = 32'd652032874;
  // atan(2^-i) in turns times 2^32
  localparam logic [31:0] AtanTab [CordicSteps] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  // Vector magnitudes between the rotation and vectoring stages
  localparam int MagW = 43;
  localparam int VecW = 47;
  localparam int AngW = 34;

  // Distance scale: 4*pi*R*2^6, applied as two partial products
  localparam logic [16:0] DistScaleHi = 17'd78183;   // bits 32..16
  localparam logic [15:0] DistScaleLo = 16'd61132;   // bits 15..0
  localparam int          DistShift   = 38;
  localparam logic [24:0] DistMax     = 25'd20037509;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LONG_LOW    = 3'd0,
    CFG_LAT_LOW     = 3'd1,
    CFG_LONG_HIGH   = 3'd2,
    CFG_LAT_HIGH    = 3'd3,
    CFG_GRID_WIDTH  = 3'd4,
    CFG_GRID_HEIGHT = 3'd5
  } cfg_idx_e;

  // Per-axis constants for the centre computation
  typedef struct packed {
    logic signed [43:0] lo_den;   // low bound times 2*(cells+1)
    logic signed [25:0] diff;     // high bound minus low bound
    logic        [42:0] modulus;  // 2*(cells+1) * 360 deg
  } axis_t;

endpackage
`default_nettype wire

>>> rtl/gncd_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncd_split
// Splits two node ids into column (id / height) and row (id % height) with a
// restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module gncd_split (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [gncd_pkg::RowW-1:0]  height_i,
  input  logic [gncd_pkg::IdW-1:0]   id_a_i,
  input  logic [gncd_pkg::IdW-1:0]   id_b_i,
  output logic                       valid_o,
  output logic [gncd_pkg::IdW-1:0]   col_a_o,
  output logic [gncd_pkg::IdW-1:0]   col_b_o,
  output logic [gncd_pkg::RowW-1:0]  row_a_o,
  output logic [gncd_pkg::RowW-1:0]  row_b_o
);

  localparam int Steps = gncd_pkg::IdW;
  localparam int IdW   = gncd_pkg::IdW;
  localparam int RowW  = gncd_pkg::RowW;

  typedef struct packed {
    logic [IdW-1:0]  nq;   // remaining dividend bits above, quotient bits below
    logic [RowW-1:0] rem;
  } div_t;

  function automatic div_t div_step(input logic [IdW-1:0] nq, input logic [RowW-1:0] rem,
                                    input logic [RowW-1:0] h);
    logic [RowW:0] trial;
    div_t          res;
    trial = {rem, nq[IdW-1]};
    if (trial >= {1'b0, h}) begin
      res.rem = RowW'(trial - {1'b0, h});
      res.nq  = {nq[IdW-2:0], 1'b1};
    end else begin
      res.rem = trial[RowW-1:0];
      res.nq  = {nq[IdW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic [Steps-1:0] vld_q;
  div_t             st_q [Steps][2];
  div_t             st_d [Steps][2];

  // one quotient bit per stage
  always_comb begin
    st_d[0][0] = div_step(id_a_i, '0, height_i);
    st_d[0][1] = div_step(id_b_i, '0, height_i);
    for (int s = 1; s < Steps; s++) begin
      for (int l = 0; l < 2; l++) begin
        st_d[s][l] = div_step(st_q[s-1][l].nq, st_q[s-1][l].rem, height_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign col_a_o = st_q[Steps-1][0].nq;
  assign col_b_o = st_q[Steps-1][1].nq;
  assign row_a_o = st_q[Steps-1][0].rem;
  assign row_b_o = st_q[Steps-1][1].rem;

endmodule
`default_nettype wire

>>> rtl/gncd_turns.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncd_turns
// Cell centres as binary angles: forms the exact centre numerator, reduces it
// modulo one turn one bit per stage, then long-divides the remainder into a
// 32-bit fraction of a turn, one bit per stage. Four lanes in parallel.
// ----------------------------------------------------------------------------
module gncd_turns (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [gncd_pkg::IdW-1:0]             col_a_i,
  input  logic [gncd_pkg::IdW-1:0]             col_b_i,
  input  logic [gncd_pkg::RowW-1:0]            row_a_i,
  input  logic [gncd_pkg::RowW-1:0]            row_b_i,
  input  gncd_pkg::axis_t                      lon_i,
  input  gncd_pkg::axis_t                      lat_i,
  output logic                                 valid_o,
  output logic [gncd_pkg::NumLanes-1:0][31:0]  turn_o
);

  localparam int Lanes     = gncd_pkg::NumLanes;
  localparam int ModSteps  = 34;   // quotient of |num| / modulus fits 34 bits
  localparam int TurnSteps = 32;
  localparam int Lat       = 3 + ModSteps + 1 + TurnSteps;

  function automatic logic [43:0] turn_step(input logic [42:0] r, input logic [42:0] m);
    logic [43:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, m}) begin
      return {1'b1, 43'(t - {1'b0, m})};
    end
    return {1'b0, t[42:0]};
  endfunction

  logic [Lat-1:0]      vld_q;
  gncd_pkg::axis_t     lane_ax [Lanes];
  logic [31:0]         idx [Lanes];

  logic signed [58:0]  prod_q [Lanes];
  logic signed [58:0]  prod_d [Lanes];
  logic signed [60:0]  num_q [Lanes];
  logic signed [60:0]  num_d [Lanes];
  logic [59:0]         rem_q [ModSteps+1][Lanes];
  logic [59:0]         rem_d [ModSteps+1][Lanes];
  logic                neg_q [ModSteps+1][Lanes];
  logic                neg_d [ModSteps+1][Lanes];
  logic [42:0]         frac_q [Lanes];
  logic [42:0]         frac_d [Lanes];
  logic [42:0]         part_q [TurnSteps][Lanes];
  logic [42:0]         part_d [TurnSteps][Lanes];
  logic [31:0]         quo_q [TurnSteps][Lanes];
  logic [31:0]         quo_d [TurnSteps][Lanes];
  logic [76:0]         msub;
  logic [43:0]         stp;

  // lane selection: west-east lanes use columns, south-north lanes rows
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      lane_ax[l] = (l < 2) ? lon_i : lat_i;
    end
    idx[0] = col_a_i;
    idx[1] = col_b_i;
    idx[2] = {16'b0, row_a_i};
    idx[3] = {16'b0, row_b_i};
  end

  // numerator, magnitude, reduction modulo one turn, fix-up, fraction
  always_comb begin
    msub = '0;
    stp  = '0;
    for (int l = 0; l < Lanes; l++) begin
      prod_d[l] = $signed({1'b0, idx[l]}) * $signed(lane_ax[l].diff);
      num_d[l]  = $signed(lane_ax[l].lo_den) + (prod_q[l] <<< 1) +
                  $signed(lane_ax[l].diff);
      neg_d[0][l] = num_q[l][60];
      rem_d[0][l] = num_q[l][60] ? 60'(-num_q[l]) : 60'(num_q[l]);
      for (int k = 0; k < ModSteps; k++) begin
        msub = {34'b0, lane_ax[l].modulus} << (ModSteps - 1 - k);
        neg_d[k+1][l] = neg_q[k][l];
        if ({17'b0, rem_q[k][l]} >= msub) begin
          rem_d[k+1][l] = 60'({17'b0, rem_q[k][l]} - msub);
        end else begin
          rem_d[k+1][l] = rem_q[k][l];
        end
      end
      // negative numerator with a nonzero remainder wraps to modulus - rem
      if (neg_q[ModSteps][l] && (rem_q[ModSteps][l] != '0)) begin
        frac_d[l] = 43'(lane_ax[l].modulus - rem_q[ModSteps][l][42:0]);
      end else begin
        frac_d[l] = rem_q[ModSteps][l][42:0];
      end
      stp = turn_step(frac_q[l], lane_ax[l].modulus);
      part_d[0][l] = stp[42:0];
      quo_d[0][l]  = {31'b0, stp[43]};
      for (int s = 1; s < TurnSteps; s++) begin
        stp = turn_step(part_q[s-1][l], lane_ax[l].modulus);
        part_d[s][l] = stp[42:0];
        quo_d[s][l]  = {quo_q[s-1][l][30:0], stp[43]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      num_q  <= num_d;
      rem_q  <= rem_d;
      neg_q  <= neg_d;
      frac_q <= frac_d;
      part_q <= part_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = vld_q[Lat-1];
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      turn_o[l] = quo_q[TurnSteps-1][l];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gncd_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncd_rot
// Half-angle differences and mean latitude, sine and cosine of each through
// a 32-stage rotation CORDIC, then the four haversine products as magnitudes
// with 40 fraction bits.
// ----------------------------------------------------------------------------
module gncd_rot (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic [gncd_pkg::NumLanes-1:0][31:0]               turn_i,
  output logic                                              valid_o,
  output logic [gncd_pkg::NumLanes-1:0][gncd_pkg::MagW-1:0] mag_o
);

  localparam int Steps = gncd_pkg::CordicSteps;
  localparam int Lanes = 3;
  localparam int Prods = gncd_pkg::NumLanes;
  localparam int AngW  = gncd_pkg::AngW;
  localparam int MagW  = gncd_pkg::MagW;
  localparam int Lat   = 1 + Steps + 4;

  typedef struct packed {
    logic signed [42:0]     x;
    logic signed [42:0]     y;
    logic signed [AngW-1:0] z;
    logic                   neg;
  } rot_t;

  function automatic rot_t rot_step(input rot_t a, input int i);
    rot_t                   r;
    logic signed [42:0]     dx;
    logic signed [42:0]     dy;
    logic signed [AngW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = $signed({2'b0, gncd_pkg::AtanTab[i]});
    r  = a;
    if (!a.z[AngW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  logic [Lat-1:0]      vld_q;
  logic [31:0]         ang [Lanes];
  logic [31:0]         qtr;
  logic [31:0]         bang;
  rot_t                cr_q [Steps+1][Lanes];
  rot_t                cr_d [Steps+1][Lanes];
  logic signed [42:0]  xr;
  logic signed [42:0]  yr;
  logic signed [31:0]  co_q [Lanes];
  logic signed [31:0]  co_d [Lanes];
  logic signed [31:0]  si_q [Lanes];
  logic signed [31:0]  si_d [Lanes];
  logic signed [63:0]  prod_q [Prods];
  logic signed [63:0]  prod_d [Prods];
  logic signed [43:0]  sh_q [Prods];
  logic signed [43:0]  sh_d [Prods];
  logic [MagW-1:0]     mag_q [Prods];
  logic [MagW-1:0]     mag_d [Prods];

  // half of lat difference, half of lat sum, half of lon difference,
  // then the CORDIC stages
  always_comb begin
    ang[0] = turn_i[3] - turn_i[2];
    ang[1] = turn_i[2] + turn_i[3];
    ang[2] = turn_i[1] - turn_i[0];
    qtr    = '0;
    bang   = '0;
    for (int l = 0; l < Lanes; l++) begin
      ang[l] = ang[l] >> 1;
      // fold the left half-plane by a half turn, negate at the end
      qtr  = ang[l] + 32'h4000_0000;
      bang = qtr[31] ? (ang[l] + 32'h8000_0000) : ang[l];
      cr_d[0][l].x   = {1'b0, gncd_pkg::GainQ30, 10'b0};
      cr_d[0][l].y   = '0;
      cr_d[0][l].z   = AngW'($signed(bang));
      cr_d[0][l].neg = qtr[31];
    end
    for (int i = 0; i < Steps; i++) begin
      for (int l = 0; l < Lanes; l++) begin
        cr_d[i+1][l] = rot_step(cr_q[i][l], i);
      end
    end
  end

  // round to 30 fraction bits, products, rounding shift, magnitude
  always_comb begin
    xr = '0;
    yr = '0;
    for (int l = 0; l < Lanes; l++) begin
      xr = (cr_q[Steps][l].x + 43'sd512) >>> 10;
      yr = (cr_q[Steps][l].y + 43'sd512) >>> 10;
      co_d[l] = 32'(cr_q[Steps][l].neg ? -xr : xr);
      si_d[l] = 32'(cr_q[Steps][l].neg ? -yr : yr);
    end
    prod_d[0] = si_q[0] * co_q[2];   // sin p * cos l
    prod_d[1] = co_q[1] * si_q[2];   // cos s * sin l
    prod_d[2] = co_q[0] * co_q[2];   // cos p * cos l
    prod_d[3] = si_q[1] * si_q[2];   // sin s * sin l
    for (int k = 0; k < Prods; k++) begin
      sh_d[k]  = 44'((prod_q[k] + 64'sd524288) >>> 20);
      mag_d[k] = MagW'(sh_q[k][43] ? -sh_q[k] : sh_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q   <= cr_d;
      co_q   <= co_d;
      si_q   <= si_d;
      prod_q <= prod_d;
      sh_q   <= sh_d;
      mag_q  <= mag_d;
    end
  end

  assign valid_o = vld_q[Lat-1];
  always_comb begin
    for (int k = 0; k < Prods; k++) begin
      mag_o[k] = mag_q[k];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gncd_vec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncd_vec
// 32-stage vectoring CORDIC: drives y toward zero, returns the scaled
// vector length and the accumulated angle in turns times 2^32.
// ----------------------------------------------------------------------------
module gncd_vec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [gncd_pkg::VecW-1:0]   x_i,
  input  logic signed [gncd_pkg::VecW-1:0]   y_i,
  output logic                               valid_o,
  output logic signed [gncd_pkg::VecW-1:0]   mag_o,
  output logic signed [gncd_pkg::AngW-1:0]   ang_o
);

  localparam int Steps = gncd_pkg::CordicSteps;
  localparam int VecW  = gncd_pkg::VecW;
  localparam int AngW  = gncd_pkg::AngW;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } vec_t;

  function automatic vec_t vec_step(input vec_t a, input int i);
    vec_t                   r;
    logic signed [VecW-1:0] dx;
    logic signed [VecW-1:0] dy;
    logic signed [AngW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = $signed({2'b0, gncd_pkg::AtanTab[i]});
    if (a.y > 0) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end
    return r;
  endfunction

  logic [Steps-1:0] vld_q;
  vec_t             st_q [Steps];
  vec_t             st_d [Steps];
  vec_t             head;

  always_comb begin
    head.x = x_i;
    head.y = y_i;
    head.z = '0;
    st_d[0] = vec_step(head, 0);
    for (int i = 1; i < Steps; i++) begin
      st_d[i] = vec_step(st_q[i-1], i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign mag_o   = st_q[Steps-1].x;
  assign ang_o   = st_q[Steps-1].z;

endmodule
`default_nettype wire

>>> rtl/grid_node_great_circle_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_node_great_circle_distance
// Great-circle distance in whole metres between the cell centres of two grid
// node ids, fully pipelined: one request per clock while in_stall_o is low.
//
// Input channel: in_valid_i / in_stall_o with first_node_i, second_node_i.
// A request is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with distance_m_o, one result per
// request, in request order.
// From acceptance to out_valid_o a request passes 32 divider stages, 70 centre
// stages, 37 rotation/product stages, two 32-stage vectoring passes, two
// scaling stages and the output buffer.
// Throughput is one request per cycle while in_stall_o is low. A two-entry
// output buffer absorbs stalls: the pipeline keeps moving and requests are
// taken while a result waits; the whole pipeline halts only when the buffer
// is full and the last stage holds a result, with nothing lost or repeated.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i;
// write only while no request is in flight. Reset clears the pipeline and
// buffer and loads the bounds -180..180 / -90..90 deg, width 1, height 1.
// ----------------------------------------------------------------------------
module grid_node_great_circle_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i,
  // requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] first_node_i,
  input  logic [31:0] second_node_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [24:0] distance_m_o
);

  localparam int NumLanes = gncd_pkg::NumLanes;
  localparam int MagW     = gncd_pkg::MagW;
  localparam int VecW     = gncd_pkg::VecW;
  localparam int AngW     = gncd_pkg::AngW;

  // configuration registers
  logic signed [24:0] long_low_q;
  logic signed [23:0] lat_low_q;
  logic signed [24:0] long_high_q;
  logic signed [23:0] lat_high_q;
  logic [15:0]        grid_width_q;
  logic [15:0]        grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_low_q    <= -25'sd11796480;
      lat_low_q     <= -24'sd5898240;
      long_high_q   <= 25'sd11796480;
      lat_high_q    <= 24'sd5898240;
      grid_width_q  <= 16'd1;
      grid_height_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (gncd_pkg::cfg_idx_e'(cfg_index_i))
        gncd_pkg::CFG_LONG_LOW:    long_low_q    <= cfg_data_i;
        gncd_pkg::CFG_LAT_LOW:     lat_low_q     <= cfg_data_i[23:0];
        gncd_pkg::CFG_LONG_HIGH:   long_high_q   <= cfg_data_i;
        gncd_pkg::CFG_LAT_HIGH:    lat_high_q    <= cfg_data_i[23:0];
        gncd_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[15:0];
        gncd_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // zero height acts as one
  logic [15:0] h_eff;
  assign h_eff = (grid_height_q == '0) ? 16'd1 : grid_height_q;

  // per-axis constants, registered; first used after the divider stages
  logic signed [24:0] lon_lo;
  logic signed [24:0] lat_lo;
  logic signed [18:0] lon_den;
  logic signed [18:0] lat_den;
  gncd_pkg::axis_t    lon_d;
  gncd_pkg::axis_t    lon_q;
  gncd_pkg::axis_t    lat_d;
  gncd_pkg::axis_t    lat_q;

  always_comb begin
    lon_lo  = long_low_q;
    lat_lo  = 25'(lat_low_q);
    lon_den = {1'b0, 17'(grid_width_q) + 17'd1, 1'b0};
    lat_den = {1'b0, 17'(h_eff) + 17'd1, 1'b0};
    lon_d.lo_den  = lon_lo * lon_den;
    lon_d.diff    = 26'(long_high_q) - 26'(long_low_q);
    lon_d.modulus = 43'(lon_den[17:0]) * 43'(gncd_pkg::FullTurnQ);
    lat_d.lo_den  = lat_lo * lat_den;
    lat_d.diff    = 26'(lat_high_q) - 26'(lat_low_q);
    lat_d.modulus = 43'(lat_den[17:0]) * 43'(gncd_pkg::FullTurnQ);
  end

  always_ff @(posedge clk_i) begin
    lon_q <= lon_d;
    lat_q <= lat_d;
  end

  // pipeline advance: halt only if the buffer is full and a result is ready
  logic        en;
  logic        sc_vld_q;
  logic [1:0]  cnt_q;
  assign en         = !((cnt_q == 2'd2) && sc_vld_q);
  assign in_stall_o = !en;

  // id split
  logic        sp_vld;
  logic [31:0] col_a;
  logic [31:0] col_b;
  logic [15:0] row_a;
  logic [15:0] row_b;

  gncd_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .height_i (h_eff),
    .id_a_i   (first_node_i),
    .id_b_i   (second_node_i),
    .valid_o  (sp_vld),
    .col_a_o  (col_a),
    .col_b_o  (col_b),
    .row_a_o  (row_a),
    .row_b_o  (row_b)
  );

  // centres as binary angles
  logic                             tn_vld;
  logic [NumLanes-1:0][31:0]        turns;

  gncd_turns u_turns (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sp_vld),
    .col_a_i (col_a),
    .col_b_i (col_b),
    .row_a_i (row_a),
    .row_b_i (row_b),
    .lon_i   (lon_q),
    .lat_i   (lat_q),
    .valid_o (tn_vld),
    .turn_o  (turns)
  );

  // sines, cosines and products
  logic                             rt_vld;
  logic [NumLanes-1:0][MagW-1:0]    mags;

  gncd_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tn_vld),
    .turn_i  (turns),
    .valid_o (rt_vld),
    .mag_o   (mags)
  );

  // vector lengths: sqrt(a) and sqrt(1-a), common gain
  logic                   va_vld;
  logic signed [VecW-1:0] ma;
  logic signed [VecW-1:0] mb;

  gncd_vec u_vec_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .x_i     ($signed({4'b0, mags[0]})),
    .y_i     ($signed({4'b0, mags[1]})),
    .valid_o (va_vld),
    .mag_o   (ma),
    .ang_o   ()
  );

  gncd_vec u_vec_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .x_i     ($signed({4'b0, mags[2]})),
    .y_i     ($signed({4'b0, mags[3]})),
    .valid_o (),
    .mag_o   (mb),
    .ang_o   ()
  );

  // central angle atan2(sqrt a, sqrt(1-a))
  logic                   vc_vld;
  logic signed [AngW-1:0] theta;

  gncd_vec u_vec_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_vld),
    .x_i     (mb),
    .y_i     (ma),
    .valid_o (vc_vld),
    .mag_o   (),
    .ang_o   (theta)
  );

  // scale to metres: two partial products, then sum, round and saturate
  logic        pp_vld_q;
  logic [31:0] zc;
  logic [48:0] ph_d;
  logic [48:0] ph_q;
  logic [47:0] pl_d;
  logic [47:0] pl_q;
  logic [65:0] dsum;
  logic [27:0] draw;
  logic [24:0] dist_d;
  logic [24:0] dist_q;

  always_comb begin
    zc   = theta[AngW-1] ? '0 : theta[31:0];
    ph_d = zc * gncd_pkg::DistScaleHi;
    pl_d = zc * gncd_pkg::DistScaleLo;
    dsum = {1'b0, ph_q, 16'b0} + 66'(pl_q) + (66'd1 << (gncd_pkg::DistShift - 1));
    draw = dsum[65:gncd_pkg::DistShift];
    dist_d = (draw > 28'(gncd_pkg::DistMax)) ? gncd_pkg::DistMax : draw[24:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
      sc_vld_q <= 1'b0;
    end else if (en) begin
      pp_vld_q <= vc_vld;
      sc_vld_q <= pp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      dist_q <= dist_d;
    end
  end

  // two-entry output buffer
  logic        push;
  logic        pop;
  logic [24:0] buf0_q;
  logic [24:0] buf1_q;

  assign push = en && sc_vld_q;
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          buf0_q <= dist_q;
        end else begin
          buf1_q <= dist_q;
        end
      end
      2'b01: begin
        buf0_q <= buf1_q;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          buf0_q <= dist_q;
        end else begin
          buf0_q <= buf1_q;
          buf1_q <= dist_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign distance_m_o = buf0_q;

endmodule
`default_nettype wire
